// File: rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = COLS * ROWS;
  // cells that move up one row on a scroll
  localparam int SHIFT_CELLS = NCELLS - COLS;

  localparam int FUNC_W = 3;
  localparam int SYM_W  = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int DATA_W = 16;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int CNT_W  = $clog2(NCELLS + 1);

  localparam logic [ATTR_W-1:0] ATTR_RESET = ATTR_W'(5);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

  localparam logic [FUNC_W-1:0] FN_PUTC    = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FN_NEWLINE = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FN_CLEAR   = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] FN_SETCUR  = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] FN_READ    = FUNC_W'(4);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

endpackage

// File: rtl/text_console_writer_unit.sv
// results: put char, newline, set cursor and unused codes give their result in the
// cycle after the request, read cell after the read state; a put char or newline that
// scrolls sweeps in the scroll state, clear and home in the clear state, one screen
// memory cell a cycle; throughput: a new request is taken in the cycle its
// predecessor's result shows; reset: cursor goes home, attribute to 5, and busy stays
// high while the screen memory is cleared; the receiver cannot stall results
module text_console_writer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tcw_pkg::FUNC_W-1:0]   func,
  input  logic [tcw_pkg::SYM_W-1:0]    symbol,
  input  logic [tcw_pkg::COL_W-1:0]    col,
  input  logic [tcw_pkg::ROW_W-1:0]    row,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data,
  output logic                         done,
  output logic [tcw_pkg::DATA_W-1:0]   cell_data,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col_now,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_now
);

  tcw_pkg::state_t state, state_next;
  logic [tcw_pkg::CNT_W-1:0]  cnt, cnt_next, cnt_dec;
  logic [tcw_pkg::COL_W-1:0]  cursor_col, cursor_col_next, sat_col;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row, cursor_row_next, sat_row;
  logic [tcw_pkg::ATTR_W-1:0] attr;
  logic                       report, report_next;
  logic                       done_next;
  logic [tcw_pkg::DATA_W-1:0] data_next;

  logic                       we, re;
  logic [tcw_pkg::ADDR_W-1:0] waddr, raddr;
  logic [tcw_pkg::DATA_W-1:0] wdata, rdata;

  tcw_ram #(
    .WIDTH(tcw_pkg::DATA_W),
    .DEPTH(tcw_pkg::NCELLS)
  ) u_screen (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sat_col = (col > tcw_pkg::COL_LAST) ? tcw_pkg::COL_LAST : col;
  assign sat_row = (row > tcw_pkg::ROW_LAST) ? tcw_pkg::ROW_LAST : row;
  assign cnt_dec = cnt - tcw_pkg::CNT_W'(1);

  assign busy           = (state != tcw_pkg::ST_IDLE);
  assign cursor_col_now = cursor_col;
  assign cursor_row_now = cursor_row;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    report_next     = report;
    done_next       = 1'b0;
    data_next       = '0;
    we              = 1'b0;
    waddr           = tcw_pkg::cell_addr(cursor_row, cursor_col);
    wdata           = {attr, symbol};
    re              = 1'b0;
    raddr           = tcw_pkg::cell_addr(sat_row, sat_col);

    case (state)
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          case (func)
            tcw_pkg::FN_PUTC: begin
              we = 1'b1;
              if (cursor_col == tcw_pkg::COL_LAST) begin
                cursor_col_next = '0;
                if (cursor_row == tcw_pkg::ROW_LAST) begin
                  state_next = tcw_pkg::ST_SCROLL;
                  cnt_next   = '0;
                end else begin
                  cursor_row_next = cursor_row + tcw_pkg::ROW_W'(1);
                  done_next       = 1'b1;
                end
              end else begin
                cursor_col_next = cursor_col + tcw_pkg::COL_W'(1);
                done_next       = 1'b1;
              end
            end
            tcw_pkg::FN_NEWLINE: begin
              cursor_col_next = '0;
              if (cursor_row == tcw_pkg::ROW_LAST) begin
                state_next = tcw_pkg::ST_SCROLL;
                cnt_next   = '0;
              end else begin
                cursor_row_next = cursor_row + tcw_pkg::ROW_W'(1);
                done_next       = 1'b1;
              end
            end
            tcw_pkg::FN_CLEAR: begin
              cursor_col_next = '0;
              cursor_row_next = '0;
              state_next      = tcw_pkg::ST_CLEAR;
              cnt_next        = '0;
              report_next     = 1'b1;
            end
            tcw_pkg::FN_SETCUR: begin
              cursor_col_next = sat_col;
              cursor_row_next = sat_row;
              done_next       = 1'b1;
            end
            tcw_pkg::FN_READ: begin
              re         = 1'b1;
              state_next = tcw_pkg::ST_READ;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        done_next  = 1'b1;
        data_next  = rdata;
        state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCROLL: begin
        // read one row ahead, write back the cell fetched in the previous cycle
        re    = (cnt < tcw_pkg::CNT_W'(tcw_pkg::SHIFT_CELLS));
        raddr = tcw_pkg::ADDR_W'(cnt + tcw_pkg::CNT_W'(tcw_pkg::COLS));
        we    = (cnt != '0);
        waddr = cnt_dec[tcw_pkg::ADDR_W-1:0];
        wdata = (cnt <= tcw_pkg::CNT_W'(tcw_pkg::SHIFT_CELLS)) ? rdata : '0;
        if (cnt == tcw_pkg::CNT_W'(tcw_pkg::NCELLS)) begin
          state_next = tcw_pkg::ST_IDLE;
          done_next  = 1'b1;
        end else begin
          cnt_next = cnt + tcw_pkg::CNT_W'(1);
        end
      end
      tcw_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt[tcw_pkg::ADDR_W-1:0];
        wdata = '0;
        if (cnt == tcw_pkg::CNT_W'(tcw_pkg::NCELLS - 1)) begin
          // the sweep after reset gives no result
          state_next  = tcw_pkg::ST_IDLE;
          done_next   = report;
          report_next = 1'b0;
        end else begin
          cnt_next = cnt + tcw_pkg::CNT_W'(1);
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::ST_CLEAR;
      cnt        <= '0;
      cursor_col <= '0;
      cursor_row <= '0;
      attr       <= tcw_pkg::ATTR_RESET;
      report     <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      report     <= report_next;
      done       <= done_next;
      if (cfg_we) begin
        attr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_data <= data_next;
  end

endmodule

// File: rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: bench/console_checker.sv
`timescale 1ns / 100ps

module console_checker
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [COL_W-1:0]  col,
  input  logic [ROW_W-1:0]  row,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_data,
  input  logic              done,
  input  logic [DATA_W-1:0] cell_data,
  input  logic [COL_W-1:0]  cursor_col_now,
  input  logic [ROW_W-1:0]  cursor_row_now,
  output int                mismatch_count,
  output int                outstanding
);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_view_t;

  logic [DATA_W-1:0] screen [NCELLS];
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ATTR_W-1:0] attribute;
  console_view_t     expected_views [$];

  function void blank_screen();
    foreach (screen[i]) screen[i] = '0;
  endfunction

  // wrap past the last column, scroll past the last row
  function void settle_cursor();
    if (cur_col >= COLS) begin
      cur_row = cur_row + 1'b1;
      cur_col = '0;
    end
    if (cur_row >= ROWS) begin
      for (int i = 0; i < SHIFT_CELLS; i++) screen[i] = screen[i + COLS];
      for (int i = SHIFT_CELLS; i < NCELLS; i++) screen[i] = '0;
      cur_col = '0;
      cur_row = ROW_LAST;
    end
  endfunction

  function automatic console_view_t apply_request(input logic [FUNC_W-1:0] f,
                                                  input logic [SYM_W-1:0]  s,
                                                  input logic [COL_W-1:0]  c,
                                                  input logic [ROW_W-1:0]  r);
    console_view_t    v;
    logic [COL_W-1:0] c_sat;
    logic [ROW_W-1:0] r_sat;
    c_sat = (c > COL_LAST) ? COL_LAST : c;
    r_sat = (r > ROW_LAST) ? ROW_LAST : r;
    v.data = '0;
    case (f)
      FN_PUTC: begin
        screen[int'(cur_row) * COLS + int'(cur_col)] = {attribute, s};
        cur_col = cur_col + 1'b1;
        settle_cursor();
      end
      FN_NEWLINE: begin
        cur_row = cur_row + 1'b1;
        cur_col = '0;
        settle_cursor();
      end
      FN_CLEAR: begin
        blank_screen();
        cur_col = '0;
        cur_row = '0;
      end
      FN_SETCUR: begin
        cur_col = c_sat;
        cur_row = r_sat;
      end
      FN_READ: v.data = screen[int'(r_sat) * COLS + int'(c_sat)];
      default: ;
    endcase
    v.col = cur_col;
    v.row = cur_row;
    return v;
  endfunction

  always @(posedge clk) begin
    console_view_t want;
    int            errs;
    errs = mismatch_count;
    if (rst) begin
      blank_screen();
      cur_col = '0;
      cur_row = '0;
      attribute = ATTR_RESET;
      expected_views.delete();
      errs = 0;
    end else begin
      if (cfg_we) attribute = cfg_data;
      if (done) begin
        if (expected_views.size() == 0) begin
          $error("result with no request pending");
          errs++;
        end else begin
          want = expected_views.pop_front();
          if (cell_data !== want.data) begin
            $error("cell_data: expected %h, got %h", want.data, cell_data);
            errs++;
          end
          if (cursor_col_now !== want.col) begin
            $error("cursor_col_now: expected %0d, got %0d", want.col, cursor_col_now);
            errs++;
          end
          if (cursor_row_now !== want.row) begin
            $error("cursor_row_now: expected %0d, got %0d", want.row, cursor_row_now);
            errs++;
          end
        end
      end
      if (start && !busy) expected_views.push_back(apply_request(func, symbol, col, row));
    end
    mismatch_count <= errs;
    outstanding <= expected_views.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] func = FN_PUTC;
  logic [SYM_W-1:0]  symbol = '0;
  logic [COL_W-1:0]  col = '0;
  logic [ROW_W-1:0]  row = '0;
  logic              cfg_we = 1'b0;
  logic [ATTR_W-1:0] cfg_data = '0;
  logic              done;
  logic [DATA_W-1:0] cell_data;
  logic [COL_W-1:0]  cursor_col_now;
  logic [ROW_W-1:0]  cursor_row_now;
  int                mismatch_count;
  int                outstanding;
  int                sender_idle_pct = 0;
  int                cycle_count = 0;

  text_console_writer_unit dut (
    .clk, .rst, .start, .busy, .func, .symbol, .col, .row, .cfg_we, .cfg_data,
    .done, .cell_data, .cursor_col_now, .cursor_row_now
  );

  console_checker console_watch (
    .clk, .rst, .start, .busy, .func, .symbol, .col, .row, .cfg_we, .cfg_data,
    .done, .cell_data, .cursor_col_now, .cursor_row_now, .mismatch_count, .outstanding
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s,
                              input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
    int gap;
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    func = f;
    symbol = s;
    col = c;
    row = r;
    do @(posedge clk); while (busy);
  endtask

  // drain every pending request before touching the attribute
  task automatic set_color_attribute(input logic [ATTR_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly text with the cursor pushed toward the bottom right so wraps and scrolls happen
  task automatic send_random_request();
    int                pick;
    logic [FUNC_W-1:0] f;
    logic [SYM_W-1:0]  s;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    pick = $urandom_range(0, 99);
    s = SYM_W'($urandom);
    c = COL_W'($urandom);
    r = ROW_W'($urandom);
    if (pick < 55) begin
      f = FN_PUTC;
    end else if (pick < 64) begin
      f = FN_NEWLINE;
    end else if (pick < 76) begin
      f = FN_SETCUR;
      if ($urandom_range(0, 1) == 0) begin
        c = COL_W'($urandom_range(COLS - 12, COLS - 1));
        r = ROW_W'($urandom_range(ROWS - 5, ROWS - 1));
      end
    end else if (pick < 92) begin
      f = FN_READ;
      if ($urandom_range(0, 3) != 0) begin
        c = COL_W'($urandom_range(0, COLS - 1));
        r = ROW_W'($urandom_range(ROWS - 7, ROWS - 1));
      end
    end else if (pick < 94) begin
      f = FN_CLEAR;
    end else begin
      f = FUNC_W'($urandom_range(int'(FN_READ) + 1, (1 << FUNC_W) - 1));
    end
    send_request(f, s, c, r);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;
    // screen memory clear after reset
    do @(posedge clk); while (busy);

    // directed part, attribute still at its reset value
    send_request(FN_READ, 8'h00, 7'd0, 5'd0);
    send_request(FN_PUTC, 8'h00, 7'd0, 5'd0);
    send_request(FN_PUTC, 8'hFF, 7'd0, 5'd0);
    send_request(FN_READ, 8'h00, 7'd0, 5'd0);
    send_request(FN_READ, 8'h00, 7'd1, 5'd0);
    send_request(FN_SETCUR, 8'h00, 7'd127, 5'd31);
    send_request(FN_PUTC, 8'h41, 7'd0, 5'd0);
    send_request(FN_READ, 8'h00, COL_LAST, ROW_LAST - 1'b1);
    send_request(FN_READ, 8'h00, 7'd0, ROW_LAST);
    send_request(FN_NEWLINE, 8'h00, 7'd0, 5'd0);
    send_request(FN_SETCUR, 8'h00, 7'd5, 5'd3);
    send_request(FN_NEWLINE, 8'h00, 7'd0, 5'd0);
    send_request(FN_SETCUR, 8'h00, COL_LAST, 5'd10);
    send_request(FN_PUTC, 8'h5A, 7'd0, 5'd0);
    send_request(FN_READ, 8'h00, COL_LAST, 5'd10);
    send_request(FN_READ, 8'h00, 7'd100, 5'd30);
    send_request(FN_READ, 8'h00, 7'd0, 5'd31);
    send_request(FN_CLEAR, 8'h00, 7'd0, 5'd0);
    send_request(FN_READ, 8'h00, COL_LAST, 5'd10);
    for (int f = int'(FN_READ) + 1; f < (1 << FUNC_W); f++)
      send_request(FUNC_W'(f), 8'h00, 7'd0, 5'd0);
    send_request(FN_SETCUR, 8'h00, 7'd0, 5'd0);
    send_request(FN_NEWLINE, 8'h00, 7'd0, 5'd0);

    for (int phase = 0; phase < 3; phase++) begin
      set_color_attribute(phase == 0 ? 8'h00 : phase == 1 ? 8'hFF : ATTR_W'($urandom));
      sender_idle_pct = (phase == 1) ? 53 : (phase == 2) ? 12 : 0;
      repeat (42) send_random_request();
    end

    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer_unit.sv
bench/console_checker.sv
bench/testbench.sv
